// File: rtl/rstp_pkg.sv
// ----------------------------------------------------------------------------
// rstp_pkg
// Shared types and constants for the rotated, scaled sprite plotter: default
// geometry, register indexes, reset values and the pipeline control words.
// ----------------------------------------------------------------------------
package rstp_pkg;

  // Default geometry.
  localparam int SPRITE_W_DEF    = 192;
  localparam int SPRITE_H_DEF    = 64;
  localparam int SCREEN_SIZE_DEF = 192;

  // Fraction bits of the Q.20 products (Q.8 offset times Q4.12 trig).
  localparam int FRAC_BITS = 20;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CENTRE_X        = 3'd0;
  localparam logic [2:0] CFG_CENTRE_Y        = 3'd1;
  localparam logic [2:0] CFG_COS_OVER_SCALE  = 3'd2;
  localparam logic [2:0] CFG_SIN_OVER_SCALE  = 3'd3;
  localparam logic [2:0] CFG_LEVEL_THRESHOLD = 3'd4;
  localparam logic [2:0] CFG_DRAW_INTENSITY  = 3'd5;

  // Configuration reset values.
  localparam logic [15:0] CENTRE_X_RST        = 16'd24576;
  localparam logic [15:0] CENTRE_Y_RST        = 16'd24576;
  localparam logic [15:0] COS_OVER_SCALE_RST  = 16'd4096;
  localparam logic [15:0] SIN_OVER_SCALE_RST  = 16'd0;
  localparam logic [7:0]  LEVEL_THRESHOLD_RST = 8'd0;
  localparam logic [7:0]  DRAW_INTENSITY_RST  = 8'd255;

  // One word as it travels through the mapping pipeline.
  typedef struct packed {
    logic        valid;
    logic        pixel;
    logic        onscreen;
    logic        load_ok;
    logic [13:0] tidx;
    logic [7:0]  level;
    logic [15:0] paddr;
  } item_t;

  // Control handed from the mapping pipeline to the sprite store stage.
  typedef struct packed {
    logic valid;
    logic pixel;
    logic draw;
    logic load_ok;
  } mem_ctl_t;

endpackage

// File: rtl/rotozoom_sprite_threshold_plot.sv
// ----------------------------------------------------------------------------
// rotozoom_sprite_threshold_plot
// Rotated, scaled sprite plotter: texel loads fill the sprite store, pixel
// words are mapped into the sprite and thresholded into screen writes.
// ----------------------------------------------------------------------------
// The block takes one word per clock on the input channel while the output
// is not stalled, and gives exactly one result word per input word, in
// order. Six pipeline registers sit on the path, the first loaded at the
// accepting edge and the last being the output register. Loads (mode 0)
// and pixel lookups (mode 1) share one single-port synchronous sprite
// store, accessed in the same pipeline stage for both, so a load is always
// visible to any pixel word that follows it, even in the next cycle.
// Throughput is one word per cycle, set by that single store port; the
// whole pipeline holds while a finished result waits on the output.
// Configuration is written through its own port, which is always ready,
// and should only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module rotozoom_sprite_threshold_plot #(
  parameter int SPRITE_W    = rstp_pkg::SPRITE_W_DEF,
  parameter int SPRITE_H    = rstp_pkg::SPRITE_H_DEF,
  parameter int SCREEN_SIZE = rstp_pkg::SCREEN_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [13:0] texel_index,
  input  logic [7:0]  texel_level,
  input  logic [7:0]  screen_x,
  input  logic [7:0]  screen_y,
  // Result words.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_enable,
  output logic [15:0] pixel_address,
  output logic [23:0] pixel_word,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rstp_pkg::*;

  localparam int DEPTH = SPRITE_W * SPRITE_H;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [15:0]        centre_x;
  logic [15:0]        centre_y;
  logic signed [15:0] cos_over_scale;
  logic signed [15:0] sin_over_scale;
  logic [7:0]         level_threshold;
  logic [7:0]         draw_intensity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x        <= CENTRE_X_RST;
      centre_y        <= CENTRE_Y_RST;
      cos_over_scale  <= COS_OVER_SCALE_RST;
      sin_over_scale  <= SIN_OVER_SCALE_RST;
      level_threshold <= LEVEL_THRESHOLD_RST;
      draw_intensity  <= DRAW_INTENSITY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CENTRE_X:        centre_x        <= cfg_data;
        CFG_CENTRE_Y:        centre_y        <= cfg_data;
        CFG_COS_OVER_SCALE:  cos_over_scale  <= cfg_data;
        CFG_SIN_OVER_SCALE:  sin_over_scale  <= cfg_data;
        CFG_LEVEL_THRESHOLD: level_threshold <= cfg_data[7:0];
        CFG_DRAW_INTENSITY:  draw_intensity  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // The pipeline advances whenever the output register is free or drained.
  logic en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Mapping pipeline.
  mem_ctl_t      m_ctl;
  logic [AW-1:0] m_addr;
  logic [7:0]    m_level;
  logic [15:0]   m_paddr;

  rstp_affine #(
    .SPRITE_W    (SPRITE_W),
    .SPRITE_H    (SPRITE_H),
    .SCREEN_SIZE (SCREEN_SIZE),
    .AW          (AW)
  ) u_affine (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .take           (in_valid && in_ready),
    .mode           (mode),
    .texel_index    (texel_index),
    .texel_level    (texel_level),
    .screen_x       (screen_x),
    .screen_y       (screen_y),
    .centre_x       (centre_x),
    .centre_y       (centre_y),
    .cos_over_scale (cos_over_scale),
    .sin_over_scale (sin_over_scale),
    .ctl            (m_ctl),
    .store_addr     (m_addr),
    .store_level    (m_level),
    .paddr          (m_paddr)
  );

  // Sprite store: one port, written by loads and read by pixel lookups.
  logic [7:0] sprite_store [DEPTH];
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (en) begin
      if (m_ctl.valid && !m_ctl.pixel && m_ctl.load_ok) begin
        sprite_store[m_addr] <= m_level;
      end
      if (m_ctl.valid && m_ctl.pixel && m_ctl.draw) begin
        rdata <= sprite_store[m_addr];
      end
    end
  end

  // Stage alongside the store read data.
  logic        s5_valid;
  logic        s5_draw;
  logic [15:0] s5_paddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= m_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_draw  <= m_ctl.valid && m_ctl.pixel && m_ctl.draw;
      s5_paddr <= m_paddr;
    end
  end

  // Output register: threshold the texel and form the screen word.
  logic hit;

  assign hit = s5_draw && (rdata > level_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      write_enable  <= hit;
      pixel_address <= s5_paddr;
      pixel_word    <= hit ? {draw_intensity, 16'h0000} : 24'h000000;
    end
  end

endmodule

// File: rtl/rstp_affine.sv
// ----------------------------------------------------------------------------
// rstp_affine
// Four-stage pipeline that maps a screen pixel back into sprite space:
// offset and multiply, sum, round and range check, then store address.
// ----------------------------------------------------------------------------
module rstp_affine #(
  parameter int SPRITE_W    = rstp_pkg::SPRITE_W_DEF,
  parameter int SPRITE_H    = rstp_pkg::SPRITE_H_DEF,
  parameter int SCREEN_SIZE = rstp_pkg::SCREEN_SIZE_DEF,
  parameter int AW          = $clog2(SPRITE_W * SPRITE_H)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 take,
  input  logic                 mode,
  input  logic [13:0]          texel_index,
  input  logic [7:0]           texel_level,
  input  logic [7:0]           screen_x,
  input  logic [7:0]           screen_y,
  input  logic [15:0]          centre_x,
  input  logic [15:0]          centre_y,
  input  logic signed [15:0]   cos_over_scale,
  input  logic signed [15:0]   sin_over_scale,
  output rstp_pkg::mem_ctl_t   ctl,
  output logic [AW-1:0]        store_addr,
  output logic [7:0]           store_level,
  output logic [15:0]          paddr
);
  import rstp_pkg::*;

  localparam int DEPTH   = SPRITE_W * SPRITE_H;
  localparam int QW      = 36;
  localparam int RW      = QW - FRAC_BITS;
  localparam int UW      = $clog2(SPRITE_W);
  localparam int VW      = $clog2(SPRITE_H);
  localparam int PXW_RAW = 8 + $clog2(SCREEN_SIZE) + 1;
  localparam int PXW     = (PXW_RAW > 16) ? PXW_RAW : 16;
  localparam logic signed [QW-1:0] OFF_U = QW'(SPRITE_W * (1 << (FRAC_BITS - 1)));
  localparam logic signed [QW-1:0] OFF_V = QW'(SPRITE_H * (1 << (FRAC_BITS - 1)));
  localparam logic signed [QW-1:0] HALF  = QW'(1 << (FRAC_BITS - 1));

  // Stage 0: offsets from the sprite centre in Q.8 and the screen address.
  logic signed [17:0] dx;
  logic signed [17:0] dy;
  logic [PXW-1:0]     paddr_full;
  item_t              s0;

  assign dx = $signed({2'b00, screen_x, 8'h00}) - $signed({2'b00, centre_x});
  assign dy = $signed({2'b00, screen_y, 8'h00}) - $signed({2'b00, centre_y});
  assign paddr_full = PXW'(screen_y) * PXW'(SCREEN_SIZE) + PXW'(screen_x);

  always_comb begin
    s0.valid    = take;
    s0.pixel    = mode;
    s0.onscreen = (32'(screen_x) < SCREEN_SIZE) && (32'(screen_y) < SCREEN_SIZE);
    s0.load_ok  = 32'(texel_index) < DEPTH;
    s0.tidx     = texel_index;
    s0.level    = texel_level;
    s0.paddr    = mode ? paddr_full[15:0] : 16'h0000;
  end

  // Stage 1: the four products, registered.
  item_t              s1;
  logic signed [33:0] prod_uc;
  logic signed [33:0] prod_us;
  logic signed [33:0] prod_vc;
  logic signed [33:0] prod_vs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (en) begin
      s1 <= s0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_uc <= dx * cos_over_scale;
      prod_us <= dy * sin_over_scale;
      prod_vc <= dy * cos_over_scale;
      prod_vs <= dx * sin_over_scale;
    end
  end

  // Stage 2: u and v in Q.20 with the sprite centre added.
  item_t              s2;
  logic signed [QW-1:0] u_q;
  logic signed [QW-1:0] v_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else if (en) begin
      s2 <= s1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_q <= QW'(prod_uc) + QW'(prod_us) + OFF_U;
      v_q <= QW'(prod_vc) - QW'(prod_vs) + OFF_V;
    end
  end

  // Stage 3: round half away from zero and check the sprite bounds.
  // A negative value takes one less in the half bias before the floor shift.
  logic signed [QW-1:0] u_adj;
  logic signed [QW-1:0] v_adj;
  logic [RW-1:0]        u_r;
  logic [RW-1:0]        v_r;
  logic                 in_sprite;

  assign u_adj     = u_q + HALF - QW'(u_q[QW-1]);
  assign v_adj     = v_q + HALF - QW'(v_q[QW-1]);
  assign u_r       = u_adj[QW-1:FRAC_BITS];
  assign v_r       = v_adj[QW-1:FRAC_BITS];
  assign in_sprite = !u_r[RW-1] && (u_r < RW'(SPRITE_W)) &&
                     !v_r[RW-1] && (v_r < RW'(SPRITE_H));

  item_t         s3;
  logic          s3_inside;
  logic [UW-1:0] u_lo;
  logic [VW-1:0] v_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else if (en) begin
      s3 <= s2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_inside <= in_sprite;
      u_lo      <= u_r[UW-1:0];
      v_lo      <= v_r[VW-1:0];
    end
  end

  // Stage 4: store address, texel row times the sprite width plus column.
  logic [AW-1:0] tex_addr;

  assign tex_addr = AW'(AW'(v_lo) * AW'(SPRITE_W)) + AW'(u_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl.valid   <= s3.valid;
      ctl.pixel   <= s3.pixel;
      ctl.draw    <= s3.onscreen && s3_inside;
      ctl.load_ok <= s3.load_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      store_addr  <= s3.pixel ? tex_addr : AW'(s3.tidx);
      store_level <= s3.level;
      paddr       <= s3.paddr;
    end
  end

endmodule

// File: test/rotozoom_sprite_threshold_plot_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotozoom_sprite_threshold_plot_tb
// Self-checking bench for the rotated, scaled sprite plotter. Texel loads and
// screen pixels are pushed through the valid/ready input channel, and each
// result word is compared with a fixed-point mapping of the pixel into a
// local copy of the sprite. Pixels that map onto the sprite always have
// their texel loaded first. Both channels idle at random, and the register
// set moves through several settings between traffic phases.
// ----------------------------------------------------------------------------
module rotozoom_sprite_threshold_plot_tb;
  import rstp_pkg::*;

  localparam int STORE_DEPTH = SPRITE_W_DEF * SPRITE_H_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 1000;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_CHOKED, RX_ALTERNATE} rx_mode_e;

  // One screen write request as the block reports it.
  typedef struct packed {
    logic        write_enable;
    logic [15:0] pixel_address;
    logic [23:0] pixel_word;
  } plot_write_t;

  // Sprite copy, register copy and the queue of screen writes still due.
  class plot_checker;
    logic [7:0]         sprite [STORE_DEPTH];
    logic [15:0]        centre_x;
    logic [15:0]        centre_y;
    logic signed [15:0] cos_q;
    logic signed [15:0] sin_q;
    logic [7:0]         threshold;
    logic [7:0]         intensity;
    plot_write_t        due_writes[$];
    int                 errors;

    function new();
      centre_x  = CENTRE_X_RST;
      centre_y  = CENTRE_Y_RST;
      cos_q     = COS_OVER_SCALE_RST;
      sin_q     = SIN_OVER_SCALE_RST;
      threshold = LEVEL_THRESHOLD_RST;
      intensity = DRAW_INTENSITY_RST;
      errors    = 0;
      foreach (sprite[i]) sprite[i] = '0;
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_CENTRE_X:        centre_x = data;
        CFG_CENTRE_Y:        centre_y = data;
        CFG_COS_OVER_SCALE:  cos_q = data;
        CFG_SIN_OVER_SCALE:  sin_q = data;
        CFG_LEVEL_THRESHOLD: threshold = data[7:0];
        CFG_DRAW_INTENSITY:  intensity = data[7:0];
        default: ;
      endcase
    endfunction

    // Q.20 to integer, ties go away from zero.
    function longint round_q20(longint q);
      if (q < 0) return -((-q + (longint'(1) <<< 19)) >>> FRAC_BITS);
      return (q + (longint'(1) <<< 19)) >>> FRAC_BITS;
    endfunction

    // Maps a screen pixel into the sprite; returns 1 with the store address
    // when the texel lies inside the sprite.
    function bit map_texel(input logic [7:0] sx, input logic [7:0] sy,
                           output int unsigned addr);
      longint dx, dy, u, v;
      addr = 0;
      if (sx >= SCREEN_SIZE_DEF || sy >= SCREEN_SIZE_DEF) return 0;
      dx = longint'(sx) * 256 - longint'(centre_x);
      dy = longint'(sy) * 256 - longint'(centre_y);
      u = round_q20(dx * longint'(cos_q) + dy * longint'(sin_q)
                    + (longint'(SPRITE_W_DEF) <<< 19));
      v = round_q20(dy * longint'(cos_q) - dx * longint'(sin_q)
                    + (longint'(SPRITE_H_DEF) <<< 19));
      if (u < 0 || u >= SPRITE_W_DEF || v < 0 || v >= SPRITE_H_DEF) return 0;
      addr = int'(v) * SPRITE_W_DEF + int'(u);
      return 1;
    endfunction

    // An accepted input word: update the sprite or predict the screen write.
    function void take_word(logic md, logic [13:0] tidx, logic [7:0] lvl,
                            logic [7:0] sx, logic [7:0] sy);
      plot_write_t w;
      int unsigned a;
      w = '0;
      if (md == MODE_LOAD) begin
        if (tidx < STORE_DEPTH) sprite[tidx] = lvl;
      end else begin
        w.pixel_address = 16'(int'(sy) * SCREEN_SIZE_DEF + int'(sx));
        if (map_texel(sx, sy, a) && sprite[a] > threshold) begin
          w.write_enable = 1'b1;
          w.pixel_word = {intensity, 16'h0000};
        end
      end
      due_writes.push_back(w);
    endfunction

    // An accepted result word against the oldest write still due.
    function void check_word(logic we, logic [15:0] addr, logic [23:0] word);
      plot_write_t e;
      if (due_writes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: we=%0d addr=%0d word=%h", we, addr, word);
        return;
      end
      e = due_writes.pop_front();
      if (e.write_enable !== we || e.pixel_address !== addr || e.pixel_word !== word) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected we=%0d addr=%0d word=%h, got we=%0d addr=%0d word=%h",
                   e.write_enable, e.pixel_address, e.pixel_word, we, addr, word);
      end
    endfunction

    function int pending();
      return due_writes.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        mode;
  logic [13:0] texel_index;
  logic [7:0]  texel_level;
  logic [7:0]  screen_x;
  logic [7:0]  screen_y;
  logic        out_valid;
  logic        out_ready;
  logic        write_enable;
  logic [15:0] pixel_address;
  logic [23:0] pixel_word;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  plot_checker chk = new();

  // Texels already loaded, so that no pixel reads an unwritten entry.
  bit texel_loaded [STORE_DEPTH];
  bit hold_go = 1'b0;
  bit steady = 1'b0;
  int burst_left = 0;
  int words_sent = 0;
  int stall_cycles = 0;

  rotozoom_sprite_threshold_plot dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .texel_index(texel_index), .texel_level(texel_level),
    .screen_x(screen_x), .screen_y(screen_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .write_enable(write_enable), .pixel_address(pixel_address),
    .pixel_word(pixel_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Both channels are watched at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        chk.take_word(mode, texel_index, texel_level, screen_x, screen_y);
      if (out_valid && out_ready)
        chk.check_word(write_enable, pixel_address, pixel_word);
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: segments of open, random, choked and alternating ready,
  // plus one long hold-off on request.
  initial begin
    rx_mode_e kind;
    int seg_len;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_go) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_go = 1'b0;
      end else begin
        kind = rx_mode_e'($urandom_range(0, 3));
        seg_len = $urandom_range(1, 40);
        for (int i = 0; i < seg_len; i++) begin
          case (kind)
            RX_OPEN:      out_ready <= 1'b1;
            RX_RANDOM:    out_ready <= $urandom_range(0, 1);
            RX_CHOKED:    out_ready <= ($urandom_range(0, 3) == 0);
            RX_ALTERNATE: out_ready <= i[0];
            default:      out_ready <= 1'b1;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offers one input word in a burst pattern and waits for its acceptance.
  task automatic offer_word(logic md, logic [13:0] ti, logic [7:0] tl,
                            logic [7:0] sx, logic [7:0] sy);
    int gap;
    if (!steady && burst_left == 0) begin
      gap = $urandom_range(0, 12);
      burst_left = $urandom_range(1, 60);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid    <= 1'b1;
    mode        <= md;
    texel_index <= ti;
    texel_level <= tl;
    screen_x    <= sx;
    screen_y    <= sy;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic offer_load(int unsigned idx, logic [7:0] lvl);
    if (idx < STORE_DEPTH) texel_loaded[idx] = 1'b1;
    offer_word(MODE_LOAD, 14'(idx), lvl, 8'($urandom), 8'($urandom));
  endtask

  // A pixel whose texel is still unknown gets a random load just before it.
  task automatic offer_pixel(logic [7:0] sx, logic [7:0] sy);
    int unsigned a;
    if (chk.map_texel(sx, sy, a) && !texel_loaded[a])
      offer_load(a, 8'($urandom));
    offer_word(MODE_PIXEL, 14'($urandom), 8'($urandom), sx, sy);
  endtask

  // Drops valid and waits until every result is back and the pipe is empty.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    chk.write_register(idx, data);
  endtask

  // Writes the whole register set, sometimes with a stray index as well.
  task automatic program_registers(logic [15:0] cx, logic [15:0] cy,
                                   logic [15:0] cs, logic [15:0] sn,
                                   logic [7:0] thr, logic [7:0] inten);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_COS_OVER_SCALE, cs);
    write_reg(CFG_SIN_OVER_SCALE, sn);
    write_reg(CFG_LEVEL_THRESHOLD, {8'($urandom), thr});
    if ($urandom_range(0, 2) == 0) write_reg(3'($urandom_range(6, 7)), 16'($urandom));
    write_reg(CFG_DRAW_INTENSITY, {8'($urandom), inten});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_trig();
    logic [15:0] mag;
    mag = 16'($urandom_range(1024, 8192));
    if ($urandom_range(0, 4) == 0) mag = 16'($urandom_range(0, 256));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [7:0] near_centre(logic [15:0] c);
    int p;
    p = int'(c >> 8) + $urandom_range(0, 48) - 24;
    if (p < 0) p = 0;
    if (p >= SCREEN_SIZE_DEF) p = SCREEN_SIZE_DEF - 1;
    return 8'(p);
  endfunction

  // Random traffic: loads, raster runs, scattered pixels and some noise.
  task automatic run_traffic(int count);
    int stop_at, r, x0, y0, run_len;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        offer_load($urandom_range(0, STORE_DEPTH - 1), 8'($urandom));
      end else if (r < 20) begin
        if ($urandom_range(0, 1)) begin
          offer_word(MODE_LOAD, 14'($urandom_range(STORE_DEPTH, 16383)), 8'($urandom),
                     8'($urandom), 8'($urandom));
          words_sent--;
        end else if ($urandom_range(0, 1)) begin
          offer_pixel(8'($urandom_range(SCREEN_SIZE_DEF, 255)), 8'($urandom));
        end else begin
          offer_pixel(8'($urandom), 8'($urandom_range(SCREEN_SIZE_DEF, 255)));
        end
      end else if (r < 35) begin
        y0 = $urandom_range(0, 1) ? near_centre(chk.centre_y)
                                  : $urandom_range(0, SCREEN_SIZE_DEF - 1);
        x0 = near_centre(chk.centre_x);
        run_len = $urandom_range(4, 16);
        for (int i = 0; i < run_len && x0 + i < SCREEN_SIZE_DEF; i++)
          offer_pixel(8'(x0 + i), 8'(y0));
      end else if ($urandom_range(0, 1)) begin
        offer_pixel(8'($urandom_range(0, SCREEN_SIZE_DEF - 1)),
                    8'($urandom_range(0, SCREEN_SIZE_DEF - 1)));
      end else begin
        offer_pixel(near_centre(chk.centre_x), near_centre(chk.centre_y));
      end
    end
  endtask

  initial begin
    int target;
    bit first_random;
    logic [15:0] cx, cy;
    rst         = 1'b1;
    in_valid    = 1'b0;
    mode        = MODE_LOAD;
    texel_index = '0;
    texel_level = '0;
    screen_x    = '0;
    screen_y    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: pixel (x, y) lands on texel (x, y - 64).
    program_registers(CENTRE_X_RST, CENTRE_Y_RST, COS_OVER_SCALE_RST,
                      SIN_OVER_SCALE_RST, LEVEL_THRESHOLD_RST, DRAW_INTENSITY_RST);
    offer_load(0, 8'd200);
    offer_load(STORE_DEPTH - 1, 8'd0);
    offer_load(STORE_DEPTH, 8'd255);
    offer_load(16383, 8'd255);
    offer_load(5000, 8'd255);
    offer_pixel(8'd0, 8'd64);
    offer_pixel(8'd191, 8'd127);
    offer_pixel(8'd0, 8'd0);
    offer_pixel(8'd191, 8'd191);
    offer_pixel(8'd255, 8'd255);
    offer_pixel(8'd200, 8'd70);
    offer_pixel(8'd10, 8'd255);
    settle();

    // Half scale (cos over scale of two) with a quarter-pixel centre: every coordinate is a tie,
    // the first row and column at minus one half.
    program_registers(16'd12352, 16'd4160, 16'd8192, 16'd0, 8'd100, 8'd170);
    offer_pixel(8'd0, 8'd0);
    offer_pixel(8'd1, 8'd1);
    offer_pixel(8'd0, 8'd3);
    offer_pixel(8'd3, 8'd0);
    offer_pixel(8'd5, 8'd7);
    settle();

    // Register extremes.
    program_registers(16'd0, 16'd0, 16'h8000, 16'h8000, 8'd0, 8'd0);
    run_traffic(50);
    settle();
    program_registers(16'd49151, 16'd49151, 16'h7FFF, 16'h7FFF, 8'd255, 8'd255);
    run_traffic(50);
    settle();

    // Random settings; the first phase runs against a long output hold-off.
    target = words_sent + RANDOM_WORDS;
    first_random = 1'b1;
    while (words_sent < target) begin
      if ($urandom_range(0, 3) == 0) begin
        cx = 16'($urandom_range(0, 49151));
        cy = 16'($urandom_range(0, 49151));
      end else begin
        cx = 16'($urandom_range(64 * 256, 128 * 256));
        cy = 16'($urandom_range(64 * 256, 128 * 256));
      end
      program_registers(cx, cy, random_trig(), random_trig(),
                        8'($urandom_range(0, 200)), 8'($urandom));
      if (first_random) begin
        hold_go = 1'b1;
        steady = 1'b1;
      end
      run_traffic($urandom_range(60, 140));
      steady = 1'b0;
      first_random = 1'b0;
      settle();
    end

    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
